/* hdl/fragment_ion_index_scorer_macros.svh */
// assertion macros for the fragment ion index scorer
// no dependencies; included by modules that carry assertions
`ifndef FRAGMENT_ION_INDEX_SCORER_MACROS_SVH
`define FRAGMENT_ION_INDEX_SCORER_MACROS_SVH
`ifndef SYNTHESIS
`define FIIS_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");
`define FIIS_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");
`else
`define FIIS_ASSERT_NOW(lbl, ant, cons)
`define FIIS_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

/* hdl/fiis_pkg.sv */
// shared types and constants of the fragment ion index scorer
// no dependencies
package fiis_pkg;

  localparam int BIN_COUNT = 65536;
  localparam int ION_DEPTH = 1048576;
  localparam int PEPTIDES  = 4096;

  localparam int BKT_W  = 21;
  localparam int BKT_AW = $clog2(BIN_COUNT + 1);
  localparam int ION_AW = $clog2(ION_DEPTH);
  localparam int ION_CW = (BKT_W > $clog2(ION_DEPTH + 1)) ? BKT_W : $clog2(ION_DEPTH + 1);
  localparam int PEP_AW = $clog2(PEPTIDES);
  localparam int DP_W   = (PEP_AW + 1 > 13) ? PEP_AW + 1 : 13;
  localparam int SUM_W  = 40;

  typedef enum logic [2:0] {
    REQ_BUCKET = 3'd0,
    REQ_ION    = 3'd1,
    REQ_START  = 3'd2,
    REQ_PEAK   = 3'd3,
    REQ_DRAIN  = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    CFG_TOL  = 2'd0,
    CFG_TOP  = 2'd1,
    CFG_IPP  = 2'd2,
    CFG_MIN  = 2'd3
  } cfg_code_t;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [19:0] load_addr;
    logic [31:0] load_value;
    logic [11:0] window_low;
    logic [11:0] window_high;
    logic [15:0] peak_bin;
    logic [19:0] peak_intensity;
  } fiis_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] peptide_id;
    logic [7:0]  b_matches;
    logic [7:0]  y_matches;
    logic [39:0] b_intensity;
    logic [39:0] y_intensity;
    logic [8:0]  shared_peaks;
  } fiis_out_t;

  typedef struct packed {
    logic [7:0]       bc;
    logic [7:0]       yc;
    logic [SUM_W-1:0] bs;
    logic [SUM_W-1:0] ys;
  } card_t;

endpackage

/* hdl/fragment_ion_index_scorer.sv */
// Fragment ion index scorer: bucket start and ion entry tables, a per-peptide
// scorecard, a 32-step shared restoring divider and the request sequencer.
// After reset the block sweeps the scorecard to zero, one entry a cycle
// (PEPTIDES entries, 4096 by default), and takes no transaction meanwhile;
// configuration writes are taken as ever. In a peak, each ion entry walked goes
// through the shared divider one quotient bit a cycle and then, when it lands in
// the window, a read-modify-write of its scorecard entry. A drain waits while
// the output register is still full; a result may wait in the output register
// while the next non-drain transaction is taken.
module fragment_ion_index_scorer
  import fiis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fiis_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output fiis_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "fragment_ion_index_scorer_macros.svh"

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PK_LO, S_PK_HI, S_PK_LAST, S_PK_WALK, S_PK_ION,
    S_PK_DIV, S_PK_CHK, S_PK_RD, S_DR_RD, S_DR_CHK, S_DR_OUT
  } state_t;

  state_t state;

  logic [3:0]  tol;
  logic [15:0] top_bin;
  logic [12:0] ipp;
  logic [7:0]  min_peaks;

  logic [11:0]     win_lo, win_hi;
  logic [DP_W-1:0] dp, dr_p;
  logic [PEP_AW-1:0] clr_idx;

  logic [15:0] pk_bin;
  logic [19:0] pk_int;
  logic [ION_CW-1:0] ion, ion_last;

  logic [31:0] div_q;
  logic [12:0] div_rem;
  logic [4:0]  div_cnt;
  logic [PEP_AW-1:0] pid;
  logic        is_b;
  logic        out_done;

  // memories
  logic [BKT_W-1:0] bucket_mem [BIN_COUNT + 1];
  logic [31:0]      ion_mem [ION_DEPTH];
  card_t            card_mem [PEPTIDES];
  logic [BKT_W-1:0] bkt_q;
  logic [31:0]      ion_q;
  card_t            card_q;

  logic              accept;
  logic [31:0]       la32, bin32, lo32, hi32;
  logic [BKT_AW-1:0] bkt_ra;
  logic [PEP_AW-1:0] card_ra, card_wa;
  logic              card_we;
  card_t             card_wd, card_upd;
  logic [12:0]       ipp_eff, half;
  logic [13:0]       rem_sh;
  logic              div_ge;
  logic              guard_ok;
  logic [DP_W-1:0]   dr_end;
  logic [8:0]        by_sum;
  logic [ION_CW-1:0] bkt_ext, last_clamp;
  logic [SUM_W:0]    b_add, y_add;
  fiis_out_t         out_rec;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign la32     = 32'(in_data.load_addr);
  assign bin32    = 32'(pk_bin);
  assign lo32     = bin32 - 32'(tol);
  assign hi32     = bin32 + 32'd1 + 32'(tol);
  assign bkt_ra   = (state == S_PK_LO) ? lo32[BKT_AW-1:0] : hi32[BKT_AW-1:0];

  assign ipp_eff = (ipp < 13'd2) ? 13'd2 : ipp;
  assign half    = ipp_eff >> 1;
  assign rem_sh  = {div_rem, div_q[31]};
  assign div_ge  = rem_sh >= {1'b0, ipp_eff};

  // peak guard, computed on the incoming transaction
  always_comb begin
    logic [31:0] ib, ih;
    ib = 32'(in_data.peak_bin);
    ih = ib + 32'd1 + 32'(tol);
    guard_ok = (ib > 32'(tol)) && (ih < 32'(top_bin)) && (ih <= 32'(BIN_COUNT));
  end

  assign dr_end = (32'(win_hi) > 32'(PEPTIDES - 1)) ? DP_W'(PEPTIDES - 1) : DP_W'(win_hi);
  assign by_sum = 9'(card_q.bc) + 9'(card_q.yc);

  assign bkt_ext    = ION_CW'(bkt_q);
  assign last_clamp = (32'(bkt_q) > 32'(ION_DEPTH)) ? ION_CW'(ION_DEPTH) : bkt_ext;

  // scorecard update with saturation
  always_comb begin
    b_add = {1'b0, card_q.bs} + (SUM_W + 1)'(pk_int);
    y_add = {1'b0, card_q.ys} + (SUM_W + 1)'(pk_int);
    card_upd = card_q;
    if (is_b) begin
      if (card_q.bc != 8'hFF) card_upd.bc = card_q.bc + 8'd1;
      card_upd.bs = b_add[SUM_W] ? {SUM_W{1'b1}} : b_add[SUM_W-1:0];
    end else begin
      if (card_q.yc != 8'hFF) card_upd.yc = card_q.yc + 8'd1;
      card_upd.ys = y_add[SUM_W] ? {SUM_W{1'b1}} : y_add[SUM_W-1:0];
    end
  end

  // result record built from the passed scorecard entry
  always_comb begin
    out_rec = '0;
    if (out_done) begin
      out_rec.result_kind = KIND_DONE;
    end else begin
      out_rec.result_kind  = KIND_RECORD;
      out_rec.peptide_id   = 12'(dr_p);
      out_rec.b_matches    = card_q.bc;
      out_rec.y_matches    = card_q.yc;
      out_rec.b_intensity  = card_q.bs;
      out_rec.y_intensity  = card_q.ys;
      out_rec.shared_peaks = by_sum;
    end
  end

  assign card_ra = (state == S_PK_CHK) ? div_q[PEP_AW-1:0] : dr_p[PEP_AW-1:0];
  assign card_we = (state == S_CLEAR) || (state == S_PK_RD) || (state == S_DR_CHK);
  assign card_wa = (state == S_CLEAR) ? clr_idx :
                   (state == S_PK_RD) ? pid : dr_p[PEP_AW-1:0];
  assign card_wd = (state == S_PK_RD) ? card_upd : '0;

  always_ff @(posedge clk) begin
    if (accept && in_data.req_type == REQ_BUCKET && la32 < 32'(BIN_COUNT + 1)) begin
      bucket_mem[la32[BKT_AW-1:0]] <= in_data.load_value[BKT_W-1:0];
    end
    bkt_q <= bucket_mem[bkt_ra];
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.req_type == REQ_ION && la32 < 32'(ION_DEPTH)) begin
      ion_mem[la32[ION_AW-1:0]] <= in_data.load_value;
    end
    ion_q <= ion_mem[ion[ION_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (card_we) begin
      card_mem[card_wa] <= card_wd;
    end
    // hold the passed entry while the record waits for the output register
    if (state != S_DR_OUT) card_q <= card_mem[card_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      tol       <= 4'd1;
      top_bin   <= 16'hFFFF;
      ipp       <= 13'd84;
      min_peaks <= 8'd4;
      win_lo    <= '0;
      win_hi    <= '0;
      dp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOL: tol       <= cfg_data[3:0];
          CFG_TOP: top_bin   <= cfg_data;
          CFG_IPP: ipp       <= cfg_data[12:0];
          CFG_MIN: min_peaks <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_DR_OUT) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == PEP_AW'(PEPTIDES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data.req_type)
              REQ_START: begin
                win_lo <= in_data.window_low;
                win_hi <= in_data.window_high;
                dp     <= DP_W'(in_data.window_low);
              end
              REQ_PEAK: begin
                pk_bin <= in_data.peak_bin;
                pk_int <= in_data.peak_intensity;
                if (guard_ok) state <= S_PK_LO;
              end
              REQ_DRAIN: begin
                dr_p <= dp;
                if (win_lo > win_hi) begin
                  out_done <= 1'b1;
                  state    <= S_DR_OUT;
                end else begin
                  state <= S_DR_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_PK_LO:   state <= S_PK_HI;
        S_PK_HI: begin
          ion   <= bkt_ext;
          state <= S_PK_LAST;
        end
        S_PK_LAST: begin
          ion_last <= last_clamp;
          state    <= S_PK_WALK;
        end
        S_PK_WALK: state <= (ion < ion_last) ? S_PK_ION : S_IDLE;
        S_PK_ION: begin
          div_q   <= ion_q;
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_PK_DIV;
        end
        S_PK_DIV: begin
          div_rem <= div_ge ? 13'(rem_sh - {1'b0, ipp_eff}) : rem_sh[12:0];
          div_q   <= {div_q[30:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) state <= S_PK_CHK;
        end
        S_PK_CHK: begin
          pid  <= div_q[PEP_AW-1:0];
          is_b <= div_rem < half;
          if (div_q >= 32'(win_lo) && div_q <= 32'(win_hi) && div_q < 32'(PEPTIDES)) begin
            state <= S_PK_RD;
          end else begin
            ion   <= ion + 1'b1;
            state <= S_PK_WALK;
          end
        end
        S_PK_RD: begin
          ion   <= ion + 1'b1;
          state <= S_PK_WALK;
        end
        S_DR_RD: begin
          if (dr_p <= dr_end) begin
            state <= S_DR_CHK;
          end else begin
            if (dr_end + 1'b1 > dp) dp <= dr_end + 1'b1;
            out_done <= 1'b1;
            state    <= S_DR_OUT;
          end
        end
        S_DR_CHK: begin
          if (by_sum >= 9'(min_peaks)) begin
            dp       <= dr_p + 1'b1;
            out_done <= 1'b0;
            state    <= S_DR_OUT;
          end else begin
            dr_p  <= dr_p + 1'b1;
            state <= S_DR_RD;
          end
        end
        S_DR_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= out_rec;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // card_q must hold the passed entry until the record is presented
  `FIIS_ASSERT_NOW(a_rem_below_div, state == S_PK_CHK, div_rem < ipp_eff)
  `FIIS_ASSERT_NOW(a_drain_in_range, state == S_DR_CHK, dr_p <= dr_end)
  `FIIS_ASSERT_NOW(a_done_zero, out_valid && out_data.result_kind == KIND_DONE,
                   out_data.shared_peaks == 9'd0 && out_data.peptide_id == 12'd0)
  `FIIS_ASSERT_NOW(a_shared_sum, out_valid && out_data.result_kind == KIND_RECORD,
                   out_data.shared_peaks == 9'(out_data.b_matches) + 9'(out_data.y_matches))

endmodule
